// File: src/pfa_pkg.sv
// shared types and constants for the packet to frame assembler
// no dependencies; imported by every module of the block

package pfa_pkg;

    // defaults for the top level parameters
    localparam int SLOTS_DEF         = 16;
    localparam int PAYLOAD_BYTES_DEF = 8192;
    localparam int MAX_PACKETS_DEF   = 256;

    // field widths
    localparam int FRAME_W   = 64;
    localparam int PNUM_W    = 16;
    localparam int SLOT_W    = 4;
    localparam int FREE_W    = 5;
    localparam int EXP_W     = 9;
    localparam int RECV_W    = 10;
    localparam int OFFSET_W  = 21;
    localparam int LOST_W    = 11;
    localparam int FRAMES_W  = 32;
    localparam int SUM_W     = 48;
    // a placed packet index is below expected_packets, at most 255
    localparam int PIDX_W    = 8;

    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 184;

    localparam logic [EXP_W-1:0]  EXPECTED_RESET = 9'd256;
    localparam logic [RECV_W-1:0] RECV_MAX       = 10'd1023;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // input selector
    localparam logic FUNC_HEADER  = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        KIND_PLACE = 2'd0,
        KIND_CLOSE = 2'd1,
        KIND_DROP  = 2'd2
    } kind_t;

    // work for one header: an optional completion record, then one placement or drop
    typedef struct packed {
        logic                       has_close;
        logic [SLOT_W-1:0]          close_slot;
        logic [FRAME_W-1:0]         close_frame;
        logic signed [LOST_W-1:0]   close_lost;
        logic [FRAMES_W-1:0]        total_frames;
        logic signed [SUM_W-1:0]    total_lost;
        kind_t                      kind;
        logic [SLOT_W-1:0]          slot;
        logic [PIDX_W-1:0]          pidx;
        logic [FRAME_W-1:0]         frame_id;
    } pfa_entry_t;

endpackage

// File: src/pfa_front.sv
// front end: takes headers and releases, keeps frame and slot state, builds work entries
// depends on pfa_pkg

module pfa_front #(
    parameter int SLOTS       = pfa_pkg::SLOTS_DEF,
    parameter int MAX_PACKETS = pfa_pkg::MAX_PACKETS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    input  logic [pfa_pkg::EXP_W-1:0]      cfg_data,
    input  logic                           in_accept,
    input  logic                           in_func,
    input  logic [pfa_pkg::FRAME_W-1:0]    in_frame,
    input  logic [pfa_pkg::PNUM_W-1:0]     in_pnum,
    output logic                           push,
    output pfa_pkg::pfa_entry_t            push_entry
);
    import pfa_pkg::*;

    logic [EXP_W-1:0]        expected_reg, expected_next;
    logic                    started_reg, started_next;
    logic [FRAME_W-1:0]      current_frame_reg, current_frame_next;
    logic [RECV_W-1:0]       received_reg, received_next;
    logic                    holding_reg, holding_next;
    logic [SLOT_W-1:0]       current_slot_reg, current_slot_next;
    logic [SLOT_W-1:0]       next_slot_reg, next_slot_next;
    logic [FREE_W-1:0]       free_reg, free_next;
    logic [FRAMES_W-1:0]     frames_reg, frames_next;
    logic signed [SUM_W-1:0] lost_sum_reg, lost_sum_next;

    logic                    do_close;
    logic                    hold_eff;
    logic [RECV_W-1:0]       recv_eff;
    logic                    drop;
    logic signed [LOST_W-1:0] lost;
    logic signed [SUM_W:0]   sum_wide;
    logic [EXP_W-1:0]        cfg_clamped;

    always_comb begin
        if (cfg_data == '0) begin
            cfg_clamped = 9'd1;
        end else if (cfg_data > EXP_W'(MAX_PACKETS)) begin
            cfg_clamped = EXP_W'(MAX_PACKETS);
        end else begin
            cfg_clamped = cfg_data;
        end
    end

    assign do_close = started_reg && (in_frame != current_frame_reg);
    assign hold_eff = started_reg && !do_close && holding_reg;
    assign recv_eff = (started_reg && !do_close) ? received_reg : '0;
    assign lost     = $signed({2'b00, expected_reg}) - $signed({1'b0, received_reg});
    assign sum_wide = {lost_sum_reg[SUM_W-1], lost_sum_reg}
                    + {{(SUM_W+1-LOST_W){lost[LOST_W-1]}}, lost};
    assign drop     = (in_pnum >= PNUM_W'(expected_reg)) || (!hold_eff && free_reg == '0);

    always_comb begin
        expected_next      = expected_reg;
        started_next       = started_reg;
        current_frame_next = current_frame_reg;
        received_next      = received_reg;
        holding_next       = holding_reg;
        current_slot_next  = current_slot_reg;
        next_slot_next     = next_slot_reg;
        free_next          = free_reg;
        frames_next        = frames_reg;
        lost_sum_next      = lost_sum_reg;
        push               = 1'b0;

        if (cfg_valid) begin
            expected_next = cfg_clamped;
        end

        if (in_accept && in_func == FUNC_RELEASE) begin
            if (free_reg < FREE_W'(SLOTS)) begin
                free_next = free_reg + 1'b1;
            end
        end else if (in_accept) begin
            push               = 1'b1;
            started_next       = 1'b1;
            current_frame_next = in_frame;
            holding_next       = hold_eff;
            received_next      = recv_eff;
            if (do_close) begin
                // saturate the running sum on signed overflow
                if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
                    lost_sum_next = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                                    : {1'b0, {(SUM_W-1){1'b1}}};
                end else begin
                    lost_sum_next = sum_wide[SUM_W-1:0];
                end
                if (frames_reg != '1) begin
                    frames_next = frames_reg + 1'b1;
                end
            end
            if (!drop) begin
                if (!hold_eff) begin
                    current_slot_next = next_slot_reg;
                    next_slot_next    = (next_slot_reg == SLOT_W'(SLOTS - 1)) ? '0
                                      : next_slot_reg + 1'b1;
                    free_next         = free_reg - 1'b1;
                    holding_next      = 1'b1;
                end
                if (recv_eff != RECV_MAX) begin
                    received_next = recv_eff + 1'b1;
                end
            end
        end
    end

    always_comb begin
        push_entry.has_close    = do_close;
        push_entry.close_slot   = holding_reg ? current_slot_reg : '0;
        push_entry.close_frame  = current_frame_reg;
        push_entry.close_lost   = lost;
        push_entry.total_frames = frames_next;
        push_entry.total_lost   = lost_sum_next;
        push_entry.kind         = drop ? KIND_DROP : KIND_PLACE;
        push_entry.slot         = drop ? '0 : current_slot_next;
        push_entry.pidx         = in_pnum[PIDX_W-1:0];
        push_entry.frame_id     = in_frame;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expected_reg      <= EXPECTED_RESET;
            started_reg       <= 1'b0;
            current_frame_reg <= '0;
            received_reg      <= '0;
            holding_reg       <= 1'b0;
            current_slot_reg  <= '0;
            next_slot_reg     <= '0;
            free_reg          <= FREE_W'(SLOTS);
            frames_reg        <= '0;
            lost_sum_reg      <= '0;
        end else begin
            expected_reg      <= expected_next;
            started_reg       <= started_next;
            current_frame_reg <= current_frame_next;
            received_reg      <= received_next;
            holding_reg       <= holding_next;
            current_slot_reg  <= current_slot_next;
            next_slot_reg     <= next_slot_next;
            free_reg          <= free_next;
            frames_reg        <= frames_next;
            lost_sum_reg      <= lost_sum_next;
        end
    end

    a_free_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        free_reg <= FREE_W'(SLOTS))
        else $error("free slot count above pool size");

    a_expected_range: assert property (@(posedge aclk) disable iff (!aresetn)
        expected_reg != '0)
        else $error("expected packet count is zero");

    a_holding_started: assert property (@(posedge aclk) disable iff (!aresetn)
        holding_reg |-> started_reg)
        else $error("slot held before any frame opened");

    a_take_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !holding_next) |-> push_entry.kind == KIND_DROP)
        else $error("packet placed without a slot");

endmodule

// File: src/pfa_queue.sv
// short queue of work entries between the front end and the output side
// depends on pfa_pkg

module pfa_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  pfa_pkg::pfa_entry_t  push_entry,
    input  logic                 pop,
    output pfa_pkg::pfa_entry_t  head,
    output logic                 empty,
    output logic                 full
);
    import pfa_pkg::*;

    pfa_entry_t          store [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head  = store[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            store[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        empty |-> !pop)
        else $error("pop from empty queue");

    a_count_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        QPTR_W'(wr_ptr_reg - rd_ptr_reg) == count_reg[QPTR_W-1:0])
        else $error("queue pointers disagree with count");

endmodule

// File: src/pfa_back.sv
// output side: turns queued work into result items through an output register
// depends on pfa_pkg

module pfa_back #(
    parameter int PAYLOAD_BYTES = pfa_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  pfa_pkg::pfa_entry_t               head,
    input  logic                              empty,
    output logic                              pop,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [pfa_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic [1:0]                        m_tuser,
    output logic                              m_tlast
);
    import pfa_pkg::*;

    logic                    valid_reg, valid_next;
    logic                    phase_reg, phase_next;
    kind_t                   kind_reg, kind_next;
    logic [SLOT_W-1:0]       slot_reg, slot_next;
    logic [OFFSET_W-1:0]     offset_reg, offset_next;
    logic [FRAME_W-1:0]      frame_reg, frame_next;
    logic [LOST_W-1:0]       lost_reg, lost_next;
    logic [FRAMES_W-1:0]     frames_reg, frames_next;
    logic [SUM_W-1:0]        sum_reg, sum_next;
    logic                    last_reg, last_next;

    logic                    load;
    logic [31:0]             offset_full;

    assign load        = !valid_reg || m_tready;
    assign offset_full = 32'(head.pidx) * 32'(PAYLOAD_BYTES);

    always_comb begin
        valid_next  = valid_reg && !m_tready;
        phase_next  = phase_reg;
        kind_next   = kind_reg;
        slot_next   = slot_reg;
        offset_next = offset_reg;
        frame_next  = frame_reg;
        lost_next   = lost_reg;
        frames_next = frames_reg;
        sum_next    = sum_reg;
        last_next   = last_reg;
        pop         = 1'b0;

        if (load && !empty) begin
            valid_next  = 1'b1;
            frames_next = head.total_frames;
            sum_next    = head.total_lost;
            if (head.has_close && !phase_reg) begin
                // completion record goes out ahead of the packet's own result
                phase_next  = 1'b1;
                kind_next   = KIND_CLOSE;
                slot_next   = head.close_slot;
                offset_next = '0;
                frame_next  = head.close_frame;
                lost_next   = head.close_lost;
                last_next   = 1'b0;
            end else begin
                phase_next  = 1'b0;
                pop         = 1'b1;
                kind_next   = head.kind;
                slot_next   = head.slot;
                offset_next = (head.kind == KIND_PLACE) ? offset_full[OFFSET_W-1:0] : '0;
                frame_next  = head.frame_id;
                lost_next   = '0;
                last_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
        kind_reg   <= kind_next;
        slot_reg   <= slot_next;
        offset_reg <= offset_next;
        frame_reg  <= frame_next;
        lost_reg   <= lost_next;
        frames_reg <= frames_next;
        sum_reg    <= sum_next;
        last_reg   <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {4'b0000, sum_reg, frames_reg, lost_reg, frame_reg, offset_reg, slot_reg};

    a_close_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && kind_reg == KIND_CLOSE) |-> !last_reg)
        else $error("completion record marked last");

    a_phase_close: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg |-> (valid_reg && kind_reg == KIND_CLOSE && !empty))
        else $error("pending phase without completion record");

    a_drop_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && kind_reg == KIND_DROP) |-> (slot_reg == '0 && offset_reg == '0))
        else $error("dropped result carries slot or offset");

endmodule

// File: src/packet_to_frame_assembler_top.sv
// packet to frame assembler: top level joining front end, work queue and output side
// depends on pfa_pkg, pfa_front, pfa_queue, pfa_back
//
// usage: s_ carries packet headers (s_tuser 0) and slot releases (s_tuser 1).
// a header may close the current frame, giving a completion record (m_tuser 1),
// and then gives a placement (m_tuser 0) or a drop (m_tuser 2) with m_tlast high.
// a release gives no item on m_.
// cfg_ writes expected_packets (clamped to 1..MAX_PACKETS); the user must write it
// only while the block is idle; the block itself does not enforce this.
// a result goes through the work queue and then the output register to m_.
// throughput: one input item per cycle while the queue is not full; the output
// register sends one result per cycle while m_tready is high, and a header that
// closes a frame sends two results. a four-entry work queue sits between front end
// and output side; s_tready drops only when that queue is full, which happens when
// m_tready is held low or when frame-closing headers arrive back to back with too
// few idle or release cycles between them to absorb their extra completion records.
// reset (aresetn low, synchronous) empties the queue and output register,
// frees all slots, clears totals and sets expected_packets to 256.

module packet_to_frame_assembler_top #(
    parameter int SLOTS         = pfa_pkg::SLOTS_DEF,
    parameter int PAYLOAD_BYTES = pfa_pkg::PAYLOAD_BYTES_DEF,
    parameter int MAX_PACKETS   = pfa_pkg::MAX_PACKETS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pfa_pkg::EXP_W-1:0]         cfg_data,    // expected_packets
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [pfa_pkg::IN_DATA_W-1:0]     s_tdata,     // frame_number, packet_number
    input  logic                              s_tuser,     // func
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // slot, byte_offset, frame_id, lost_packets, total_frames, total_lost, pad
    output logic [pfa_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic [1:0]                        m_tuser,     // kind
    output logic                              m_tlast      // last
);
    import pfa_pkg::*;

    logic        in_accept;
    logic        push;
    pfa_entry_t  push_entry;
    pfa_entry_t  head;
    logic        pop;
    logic        empty;
    logic        full;

    assign cfg_ready = 1'b1;
    assign s_tready  = !full;
    assign in_accept = s_tvalid && s_tready;

    pfa_front #(
        .SLOTS       (SLOTS),
        .MAX_PACKETS (MAX_PACKETS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .in_accept  (in_accept),
        .in_func    (s_tuser),
        .in_frame   (s_tdata[FRAME_W-1:0]),
        .in_pnum    (s_tdata[FRAME_W+PNUM_W-1:FRAME_W]),
        .push       (push),
        .push_entry (push_entry)
    );

    pfa_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .empty      (empty),
        .full       (full)
    );

    pfa_back #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .empty    (empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
